FILE: src/ehv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehv_pkg
// Shared types, sizes and helpers of the ellipse Hough vote accumulator.
// ----------------------------------------------------------------------------
package ehv_pkg;

  localparam int unsigned ACC_DEPTH  = 1024;
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned IDX_W      = $clog2(ACC_DEPTH);
  localparam int unsigned NHIST      = 5;

  localparam int unsigned CAND_W    = 12;
  localparam int unsigned ANGLE_W   = 9;
  localparam int unsigned SEMI_W    = 10;
  localparam int unsigned PEAK_W    = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned MAG_W     = 13;
  localparam int unsigned PROD_W    = 15;
  localparam int unsigned ANG_EXT_W = 10;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SEMI_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEMI_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SEMI_B = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEMI_B = 2'd3;

  localparam logic [SEMI_W-1:0] MIN_SEMI_A_RST = 10'd147;
  localparam logic [SEMI_W-1:0] MAX_SEMI_A_RST = 10'd345;
  localparam logic [SEMI_W-1:0] MIN_SEMI_B_RST = 10'd102;
  localparam logic [SEMI_W-1:0] MAX_SEMI_B_RST = 10'd288;

  // histogram slots
  localparam int unsigned H_A   = 0;
  localparam int unsigned H_B   = 1;
  localparam int unsigned H_XC  = 2;
  localparam int unsigned H_YC  = 3;
  localparam int unsigned H_ANG = 4;

  localparam logic [MAG_W-1:0]     DEPTH_LIM  = MAG_W'(ACC_DEPTH);
  localparam logic [ANG_EXT_W-1:0] ANGLE_WRAP = 10'd360;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [PEAK_W-1:0]     peak_t;

  localparam idx_t LAST_IDX = IDX_W'(ACC_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_VOTE,
    ST_CLEAR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic capture;
    logic vote;
    logic sweep;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
  } sts_t;

  function automatic cnt_t sat_inc(cnt_t c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

endpackage

FILE: src/ehv_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehv_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ehv_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/ehv_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehv_datapath
// Candidate checks, five histogram memories, peak tracking and result word.
// ----------------------------------------------------------------------------
module ehv_datapath import ehv_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cmd_t                        cmd_i,
  output sts_t                        sts_o,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [SEMI_W-1:0]           cfg_wdata_i,
  input  logic                        action_i,
  input  logic signed [CAND_W-1:0]    cand_a_i,
  input  logic signed [CAND_W-1:0]    cand_b_i,
  input  logic signed [CAND_W-1:0]    cand_xc_i,
  input  logic signed [CAND_W-1:0]    cand_yc_i,
  input  logic signed [ANGLE_W-1:0]   cand_angle_i,
  output logic                        accepted_o,
  output peak_t                       peak_a_o,
  output peak_t                       peak_b_o,
  output peak_t                       peak_xc_o,
  output peak_t                       peak_yc_o,
  output peak_t                       peak_angle_o
);

  logic [SEMI_W-1:0] min_a_q, max_a_q, min_b_q, max_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_a_q <= MIN_SEMI_A_RST;
      max_a_q <= MAX_SEMI_A_RST;
      min_b_q <= MIN_SEMI_B_RST;
      max_b_q <= MAX_SEMI_B_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_SEMI_A: min_a_q <= cfg_wdata_i;
        CFG_MAX_SEMI_A: max_a_q <= cfg_wdata_i;
        CFG_MIN_SEMI_B: min_b_q <= cfg_wdata_i;
        CFG_MAX_SEMI_B: max_b_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // candidate checks
  logic               pos_a, pos_b, pos_x, pos_y;
  logic [MAG_W-1:0]   a_m, b_m, x_m, y_m;
  logic [PROD_W-1:0]  a_w, b_w, b10, a7, a9;
  logic               cand_ok;
  logic [ANG_EXT_W-1:0] ang_ext, ang_fix;
  idx_t               rd_idx [NHIST];

  assign pos_a = !cand_a_i[CAND_W-1] && (cand_a_i != '0);
  assign pos_b = !cand_b_i[CAND_W-1] && (cand_b_i != '0);
  assign pos_x = !cand_xc_i[CAND_W-1] && (cand_xc_i != '0);
  assign pos_y = !cand_yc_i[CAND_W-1] && (cand_yc_i != '0);

  assign a_m = {2'b00, cand_a_i[CAND_W-2:0]};
  assign b_m = {2'b00, cand_b_i[CAND_W-2:0]};
  assign x_m = {2'b00, cand_xc_i[CAND_W-2:0]};
  assign y_m = {2'b00, cand_yc_i[CAND_W-2:0]};

  assign a_w = {2'b00, a_m};
  assign b_w = {2'b00, b_m};
  assign b10 = (b_w << 3) + (b_w << 1);
  assign a7  = (a_w << 3) - a_w;
  assign a9  = (a_w << 3) + a_w;

  assign cand_ok = pos_a && pos_b && pos_x && pos_y
                && (a_m < DEPTH_LIM) && (b_m < DEPTH_LIM)
                && (x_m < DEPTH_LIM) && (y_m < DEPTH_LIM)
                && (a_m >= {3'b000, min_a_q}) && (a_m <= {3'b000, max_a_q})
                && (b_m >= {3'b000, min_b_q}) && (b_m <= {3'b000, max_b_q})
                && (b10 >= a7) && (b10 <= a9);

  // negative angles wrap by a full turn
  assign ang_ext = ANG_EXT_W'(cand_angle_i);
  assign ang_fix = cand_angle_i[ANGLE_W-1] ? ang_ext + ANGLE_WRAP : ang_ext;

  assign rd_idx[H_A]   = IDX_W'(cand_a_i[CAND_W-2:0]);
  assign rd_idx[H_B]   = IDX_W'(cand_b_i[CAND_W-2:0]);
  assign rd_idx[H_XC]  = IDX_W'(cand_xc_i[CAND_W-2:0]);
  assign rd_idx[H_YC]  = IDX_W'(cand_yc_i[CAND_W-2:0]);
  assign rd_idx[H_ANG] = IDX_W'(ang_fix);

  // captured word
  logic ok_q;
  idx_t idx_q [NHIST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= 1'b0;
    end else if (cmd_i.capture) begin
      ok_q <= !action_i && cand_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      idx_q <= rd_idx;
    end
  end

  // clearing sweep address
  idx_t sweep_cnt_q, sweep_cnt_d;
  logic sweep_last;

  assign sweep_last = (sweep_cnt_q == LAST_IDX);
  assign sweep_cnt_d = sweep_last ? '0 : sweep_cnt_q + 1'b1;
  assign sts_o.sweep_last = sweep_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_cnt_q <= '0;
    end else if (cmd_i.sweep) begin
      sweep_cnt_q <= sweep_cnt_d;
    end
  end

  // histograms and peaks
  logic  bump;
  idx_t  peak_idx_q [NHIST];
  idx_t  peak_idx_d [NHIST];
  cnt_t  peak_cnt_q [NHIST];
  cnt_t  peak_cnt_d [NHIST];
  peak_t peak_out_q [NHIST];
  logic  accepted_q;

  assign bump = cmd_i.vote && ok_q;

  for (genvar k = 0; k < NHIST; k++) begin : g_hist
    cnt_t rdata;
    cnt_t cnt_new;
    logic we;
    idx_t waddr;
    cnt_t wdata;

    assign cnt_new = sat_inc(rdata);
    assign we      = cmd_i.sweep || bump;
    assign waddr   = cmd_i.sweep ? sweep_cnt_q : idx_q[k];
    assign wdata   = cmd_i.sweep ? '0 : cnt_new;

    ehv_ram #(
      .WIDTH(COUNT_BITS),
      .DEPTH(ACC_DEPTH)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (we),
      .waddr_i(waddr),
      .wdata_i(wdata),
      .re_i   (cmd_i.capture),
      .raddr_i(rd_idx[k]),
      .rdata_o(rdata)
    );

    always_comb begin
      peak_idx_d[k] = peak_idx_q[k];
      peak_cnt_d[k] = peak_cnt_q[k];
      if (cmd_i.sweep) begin
        peak_idx_d[k] = '0;
        peak_cnt_d[k] = '0;
      end else if (bump && (cnt_new > peak_cnt_q[k])) begin
        // strictly greater only: a tie keeps the earlier peak
        peak_idx_d[k] = idx_q[k];
        peak_cnt_d[k] = cnt_new;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        peak_idx_q[k] <= '0;
        peak_cnt_q[k] <= '0;
      end else begin
        peak_idx_q[k] <= peak_idx_d[k];
        peak_cnt_q[k] <= peak_cnt_d[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.out_load) begin
        peak_out_q[k] <= PEAK_W'(peak_idx_d[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      accepted_q <= ok_q;
    end
  end

  assign accepted_o   = accepted_q;
  assign peak_a_o     = peak_out_q[H_A];
  assign peak_b_o     = peak_out_q[H_B];
  assign peak_xc_o    = peak_out_q[H_XC];
  assign peak_yc_o    = peak_out_q[H_YC];
  assign peak_angle_o = peak_out_q[H_ANG];

endmodule

FILE: src/ehv_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehv_ctrl
// Sequencer: init sweep, capture, vote, clear sweep and result hand-off.
// ----------------------------------------------------------------------------
module ehv_ctrl import ehv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic action_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_INIT: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = action_i ? ST_CLEAR : ST_VOTE;
        end
      end
      ST_VOTE: begin
        cmd_o.vote = 1'b1;
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // result waits for the output register to free up
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  assign out_valid_d = cmd_o.out_load || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

endmodule

FILE: src/ellipse_hough_vote_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ellipse_hough_vote_accumulator
// Vote stage of a randomized Hough ellipse detector with five histograms.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  in       | in_valid_i/in_ready_o  | action, cand_a/b/xc/yc, cand_angle
//  out      | out_valid_o/out_ready_i| accepted, peak_a/b/xc/yc/angle
//  cfg      | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
//  a vote word is accepted with the histogram read, followed by the
//  read-modify-write of each histogram RAM and the peak compare
//  a clear word runs the one-entry-per-cycle zeroing sweep of the
//  histogram RAMs before its result word is loaded
//  after reset the same sweep runs with in_ready_o low
//  a stalled output holds the next word in its last cycle until taken
// ----------------------------------------------------------------------------
module ellipse_hough_vote_accumulator import ehv_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [SEMI_W-1:0]         cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      action_i,
  input  logic signed [CAND_W-1:0]  cand_a_i,
  input  logic signed [CAND_W-1:0]  cand_b_i,
  input  logic signed [CAND_W-1:0]  cand_xc_i,
  input  logic signed [CAND_W-1:0]  cand_yc_i,
  input  logic signed [ANGLE_W-1:0] cand_angle_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      accepted_o,
  output logic [PEAK_W-1:0]         peak_a_o,
  output logic [PEAK_W-1:0]         peak_b_o,
  output logic [PEAK_W-1:0]         peak_xc_o,
  output logic [PEAK_W-1:0]         peak_yc_o,
  output logic [PEAK_W-1:0]         peak_angle_o
);

  cmd_t cmd;
  sts_t sts;

  ehv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ehv_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .action_i    (action_i),
    .cand_a_i    (cand_a_i),
    .cand_b_i    (cand_b_i),
    .cand_xc_i   (cand_xc_i),
    .cand_yc_i   (cand_yc_i),
    .cand_angle_i(cand_angle_i),
    .accepted_o  (accepted_o),
    .peak_a_o    (peak_a_o),
    .peak_b_o    (peak_b_o),
    .peak_xc_o   (peak_xc_o),
    .peak_yc_o   (peak_yc_o),
    .peak_angle_o(peak_angle_o)
  );

endmodule

FILE: src/ehv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehv_checker
// Port-level checks of the ellipse Hough vote accumulator.
// ----------------------------------------------------------------------------
module ehv_checker import ehv_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic              accepted_o,
  input logic [PEAK_W-1:0] peak_a_o
);

  // one word at a time: ready drops right after an accept
  a_accept_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted on two consecutive edges");

  // a result appears only out of a working state
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without work in progress");

  // the init sweep holds off input right after reset
  a_init_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready_o && !out_valid_o)
    else $error("ready or valid during init sweep");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(accepted_o)
      && $stable(peak_a_o))
    else $error("stalled result changed");

endmodule

bind ellipse_hough_vote_accumulator ehv_checker u_checker (.*);

FILE: dv/ehv_vote_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehv_vote_checker
// Watches the configuration, input and result ports of the ellipse vote
// accumulator. It keeps its own histograms, peaks and bounds, and compares
// every result word field by field with the oldest predicted word.
// ----------------------------------------------------------------------------
module ehv_vote_checker import ehv_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [SEMI_W-1:0]         cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic                      action_i,
  input  logic signed [CAND_W-1:0]  cand_a_i,
  input  logic signed [CAND_W-1:0]  cand_b_i,
  input  logic signed [CAND_W-1:0]  cand_xc_i,
  input  logic signed [CAND_W-1:0]  cand_yc_i,
  input  logic signed [ANGLE_W-1:0] cand_angle_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic                      accepted_i,
  input  logic [PEAK_W-1:0]         peak_a_i,
  input  logic [PEAK_W-1:0]         peak_b_i,
  input  logic [PEAK_W-1:0]         peak_xc_i,
  input  logic [PEAK_W-1:0]         peak_yc_i,
  input  logic [PEAK_W-1:0]         peak_angle_i,
  output int                        pending_o,
  output int                        fail_count_o
);

  typedef struct packed {
    logic  accepted;
    peak_t a;
    peak_t b;
    peak_t xc;
    peak_t yc;
    peak_t angle;
  } peak_word_t;

  cnt_t              tally [NHIST][ACC_DEPTH];
  idx_t              peak_idx [NHIST];
  logic [SEMI_W-1:0] min_a, max_a, min_b, max_b;
  peak_word_t        expected_peaks_q [$];
  peak_word_t        head_word;
  int                mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic void wipe_tallies();
    foreach (tally[h, i]) tally[h][i] = '0;
    foreach (peak_idx[h]) peak_idx[h] = '0;
  endfunction

  // saturating count, peak moves only on a strictly higher count
  function automatic void bump(int h, idx_t i);
    if (tally[h][i] != '1) tally[h][i] = tally[h][i] + 1'b1;
    if (tally[h][peak_idx[h]] < tally[h][i]) peak_idx[h] = i;
  endfunction

  function automatic peak_word_t tally_candidate(
    input logic                      clear,
    input logic signed [CAND_W-1:0]  a, b, xc, yc,
    input logic signed [ANGLE_W-1:0] ang
  );
    peak_word_t res;
    int         sa, sb, sx, sy, sg;
    logic       ok;
    sa = a;
    sb = b;
    sx = xc;
    sy = yc;
    sg = ang;
    ok = 1'b0;
    if (clear) begin
      wipe_tallies();
    end else begin
      ok = sa > 0 && sb > 0 && sx > 0 && sy > 0
        && sa < int'(ACC_DEPTH) && sb < int'(ACC_DEPTH)
        && sx < int'(ACC_DEPTH) && sy < int'(ACC_DEPTH)
        && sa >= int'(min_a) && sa <= int'(max_a)
        && sb >= int'(min_b) && sb <= int'(max_b)
        && 10 * sb >= 7 * sa && 10 * sb <= 9 * sa;
      if (ok) begin
        if (sg < 0) sg += 360;
        bump(H_A, idx_t'(sa));
        bump(H_B, idx_t'(sb));
        bump(H_XC, idx_t'(sx));
        bump(H_YC, idx_t'(sy));
        bump(H_ANG, idx_t'(sg));
      end
    end
    res.accepted = ok;
    res.a        = peak_t'(peak_idx[H_A]);
    res.b        = peak_t'(peak_idx[H_B]);
    res.xc       = peak_t'(peak_idx[H_XC]);
    res.yc       = peak_t'(peak_idx[H_YC]);
    res.angle    = peak_t'(peak_idx[H_ANG]);
    return res;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wipe_tallies();
      min_a = MIN_SEMI_A_RST;
      max_a = MAX_SEMI_A_RST;
      min_b = MIN_SEMI_B_RST;
      max_b = MAX_SEMI_B_RST;
      expected_peaks_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIN_SEMI_A: min_a = cfg_wdata_i;
          CFG_MAX_SEMI_A: max_a = cfg_wdata_i;
          CFG_MIN_SEMI_B: min_b = cfg_wdata_i;
          CFG_MAX_SEMI_B: max_b = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        expected_peaks_q = {expected_peaks_q,
                            tally_candidate(action_i, cand_a_i, cand_b_i,
                                            cand_xc_i, cand_yc_i, cand_angle_i)};
      if (out_valid_i && out_ready_i) begin
        if (expected_peaks_q.size() == 0) begin
          $display("%0t ns: result word expected none, got accepted=%0d peaks %0d %0d %0d %0d %0d",
                   $time, accepted_i, peak_a_i, peak_b_i, peak_xc_i, peak_yc_i,
                   peak_angle_i);
          mismatches++;
        end else begin
          head_word = expected_peaks_q.pop_front();
          check_field("accepted", head_word.accepted, accepted_i);
          check_field("peak_a", head_word.a, peak_a_i);
          check_field("peak_b", head_word.b, peak_b_i);
          check_field("peak_xc", head_word.xc, peak_xc_i);
          check_field("peak_yc", head_word.yc, peak_yc_i);
          check_field("peak_angle", head_word.angle, peak_angle_i);
        end
      end
      pending_o <= expected_peaks_q.size();
    end
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives candidate and clear words into the ellipse vote accumulator under
// several bound settings, with random gaps and stalls on both channels, and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;
  import ehv_pkg::*;

  localparam int QUIET_LIMIT = 8000;

  logic                      clk_i        = 1'b0;
  logic                      rst_ni       = 1'b0;
  logic                      cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_idx_i    = CFG_MIN_SEMI_A;
  logic [SEMI_W-1:0]         cfg_wdata_i  = '0;
  logic                      in_valid_i   = 1'b0;
  logic                      in_ready_o;
  logic                      action_i     = 1'b0;
  logic signed [CAND_W-1:0]  cand_a_i     = '0;
  logic signed [CAND_W-1:0]  cand_b_i     = '0;
  logic signed [CAND_W-1:0]  cand_xc_i    = '0;
  logic signed [CAND_W-1:0]  cand_yc_i    = '0;
  logic signed [ANGLE_W-1:0] cand_angle_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i  = 1'b0;
  logic                      accepted_o;
  logic [PEAK_W-1:0]         peak_a_o, peak_b_o, peak_xc_o, peak_yc_o, peak_angle_o;

  int pending;
  int fail_count;
  int quiet_cycles = 0;
  int lim_min_a    = MIN_SEMI_A_RST;
  int lim_max_a    = MAX_SEMI_A_RST;
  int lim_min_b    = MIN_SEMI_B_RST;
  int lim_max_b    = MAX_SEMI_B_RST;
  int focus_x, focus_y, focus_ang;
  bit tx_calm      = 1'b0;

  ellipse_hough_vote_accumulator dut (.*);

  ehv_vote_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .action_i     (action_i),
    .cand_a_i     (cand_a_i),
    .cand_b_i     (cand_b_i),
    .cand_xc_i    (cand_xc_i),
    .cand_yc_i    (cand_yc_i),
    .cand_angle_i (cand_angle_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .accepted_i   (accepted_o),
    .peak_a_i     (peak_a_o),
    .peak_b_i     (peak_b_o),
    .peak_xc_i    (peak_xc_o),
    .peak_yc_i    (peak_yc_o),
    .peak_angle_i (peak_angle_o),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always #6 clk_i = ~clk_i;

  // no word moving on either channel for too long means a hang
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls, calm stretches, and two long hold-offs
  initial begin : result_sink
    int unsigned stall;
    int unsigned taken;
    bit          calm;
    taken = 0;
    calm  = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      taken++;
      if ($urandom_range(0, 39) == 0) calm = !calm;
      if (taken == 150 || taken == 700) stall = 250;
      else stall = calm ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  task automatic present_word(logic act, int a, int b, int xc, int yc, int ang);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 11);
    if ($urandom_range(0, 29) == 0) tx_calm = !tx_calm;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    cand_a_i     <= CAND_W'(a);
    cand_b_i     <= CAND_W'(b);
    cand_xc_i    <= CAND_W'(xc);
    cand_yc_i    <= CAND_W'(yc);
    cand_angle_i <= ANGLE_W'(ang);
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= SEMI_W'(val);
    @(posedge clk_i);
  endtask

  // bounds change only once every outstanding result word is back
  task automatic program_bounds(int mina, int maxa, int minb, int maxb);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
    write_reg(CFG_MIN_SEMI_A, mina);
    write_reg(CFG_MAX_SEMI_A, maxa);
    write_reg(CFG_MIN_SEMI_B, minb);
    write_reg(CFG_MAX_SEMI_B, maxb);
    cfg_we_i  <= 1'b0;
    lim_min_a = mina;
    lim_max_a = maxa;
    lim_min_b = minb;
    lim_max_b = maxb;
  endtask

  task automatic program_random_bounds();
    int mina, maxa, minb, maxb;
    mina = $urandom_range(1, 700);
    maxa = mina + int'($urandom_range(20, 320));
    if (maxa > 1023) maxa = 1023;
    minb = (mina * 7) / 10 - int'($urandom_range(0, 40));
    if (minb < 0) minb = 0;
    maxb = (maxa * 9) / 10 - int'($urandom_range(0, 60));
    if (maxb < minb) maxb = minb;
    program_bounds(mina, maxa, minb, maxb);
  endtask

  // a candidate that fits the current bounds, optionally pushed just outside
  task automatic offer_candidate(bit spoil);
    int a, b, lo, hi, xc, yc, ang, near_top;
    if (lim_min_a <= lim_max_a) begin
      near_top = (lim_min_a + 7 < lim_max_a) ? lim_min_a + 7 : lim_max_a;
      if ($urandom_range(0, 1)) a = $urandom_range(lim_min_a, near_top);
      else a = $urandom_range(lim_min_a, lim_max_a);
    end else begin
      a = $urandom_range(1, 1023);
    end
    lo = (7 * a + 9) / 10;
    hi = (9 * a) / 10;
    if (lo < lim_min_b) lo = lim_min_b;
    if (hi > lim_max_b) hi = lim_max_b;
    b   = (lo <= hi) ? int'($urandom_range(lo, hi)) : lo;
    xc  = $urandom_range(0, 1) ? focus_x + int'($urandom_range(0, 3)) : $urandom_range(1, 1023);
    yc  = $urandom_range(0, 1) ? focus_y + int'($urandom_range(0, 3)) : $urandom_range(1, 1023);
    ang = $urandom_range(0, 1) ? focus_ang + int'($urandom_range(0, 3)) : $urandom_range(0, 511);
    if (spoil) begin
      case ($urandom_range(0, 5))
        0: b = lo - 1;
        1: b = hi + 1;
        2: a = lim_min_a - 1;
        3: a = lim_max_a + 1;
        4: xc = $urandom_range(0, 1) ? 0 : 1024;
        default: yc = -int'($urandom_range(1, 2048));
      endcase
    end
    present_word(1'b0, a, b, xc, yc, ang);
  endtask

  task automatic run_random(int count);
    int unsigned pick;
    focus_x   = $urandom_range(1, 1020);
    focus_y   = $urandom_range(1, 1020);
    focus_ang = $urandom_range(0, 508);
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 2)
        present_word(1'b1, $urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 511));
      else if (pick < 17)
        present_word(1'b0, $urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 511));
      else if (pick < 30)
        offer_candidate(1'b1);
      else
        offer_candidate(1'b0);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed words under the reset bounds
    present_word(1'b1, 4095, 4095, 4095, 4095, 511);    // clear, fields all ones
    present_word(1'b0, 200, 160, 10, 20, -1);           // negative angle wraps
    present_word(1'b0, 200, 160, 11, 20, 5);            // tie keeps earlier peak
    present_word(1'b0, 210, 160, 11, 21, 5);            // peak moves on higher count
    present_word(1'b0, 147, 103, 1, 1023, -256);        // lowest a, tightest ratio
    present_word(1'b0, 345, 288, 1023, 1, 255);         // upper bounds
    present_word(1'b0, 146, 110, 50, 50, 0);            // a under min
    present_word(1'b0, 346, 280, 50, 50, 0);            // a over max
    present_word(1'b0, 345, 289, 50, 50, 0);            // b over max, ratio fine
    present_word(1'b0, 200, 139, 50, 50, 0);            // ratio just too low
    present_word(1'b0, 200, 140, 50, 50, 0);            // ratio low edge
    present_word(1'b0, 200, 181, 50, 50, 0);            // ratio just too high
    present_word(1'b0, 200, 180, 50, 50, -180);         // ratio high edge
    present_word(1'b0, 0, 0, 0, 0, 0);
    present_word(1'b0, -200, -160, 50, 50, 0);
    present_word(1'b0, 200, 160, 0, 50, 0);
    present_word(1'b0, 200, 160, 50, -1, 0);
    present_word(1'b0, 200, 160, 1024, 50, 0);          // center at depth
    present_word(1'b0, 200, 160, 50, 2047, 0);
    present_word(1'b0, 2047, 2047, -2048, -2048, 0);
    present_word(1'b0, 1024, 800, 50, 50, 0);           // axis beyond depth
    present_word(1'b1, 0, 0, 0, 0, 0);                  // clear mid-stream
    present_word(1'b0, 300, 250, 500, 600, 90);

    program_bounds(0, 1023, 0, 1023);
    run_random(220);
    program_bounds(500, 100, 300, 50);                  // inverted bounds
    run_random(60);
    program_bounds(1023, 1023, 1023, 1023);
    run_random(20);
    program_bounds(200, 200, 140, 180);
    run_random(150);
    repeat (3) begin
      program_random_bounds();
      run_random(200);
    end
    program_bounds(MIN_SEMI_A_RST, MAX_SEMI_A_RST, MIN_SEMI_B_RST, MAX_SEMI_B_RST);
    run_random(150);

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (16) @(posedge clk_i);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
